// ===== rtl/core/deq_pkg.sv =====
// shared types, operation codes and status codes for the double-ended queue
package deq_pkg;

  // default number of entries
  localparam int unsigned DEPTH_DEFAULT = 16;

  // payload widths fixed by the word format
  localparam int unsigned OP_W     = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

  // input word
  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] data_value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
  } out_word_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic clear;
  } cell_cmd_t;

endpackage

// ===== rtl/core/deq_cell.sv =====
// one storage cell of the deque chain, holding one entry and its occupied flag
module deq_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  deq_pkg::cell_cmd_t                cmd,
  input  logic signed [deq_pkg::DATA_W-1:0] push_val,
  input  logic signed [deq_pkg::DATA_W-1:0] left_val,
  input  logic                              left_occ,
  input  logic signed [deq_pkg::DATA_W-1:0] right_val,
  input  logic                              right_occ,
  output logic signed [deq_pkg::DATA_W-1:0] val,
  output logic                              occ,
  output logic signed [deq_pkg::DATA_W-1:0] tap_val
);

  logic                              occ_r;
  logic                              occ_nxt;
  logic signed [deq_pkg::DATA_W-1:0] val_r;
  logic signed [deq_pkg::DATA_W-1:0] val_nxt;
  logic                              is_last;

  // this cell holds the back entry
  assign is_last = occ_r && !right_occ;

  // next entry and flag from the command and the neighbours
  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (cmd.clear) begin
      occ_nxt = 1'b0;
    end else if (cmd.push_front) begin
      occ_nxt = left_occ;
      val_nxt = left_val;
    end else if (cmd.push_back) begin
      // first free cell takes the new word
      if (!occ_r && left_occ) begin
        occ_nxt = 1'b1;
        val_nxt = push_val;
      end
    end else if (cmd.pop_front) begin
      occ_nxt = right_occ;
      val_nxt = right_val;
    end else if (cmd.pop_back) begin
      if (is_last) begin
        occ_nxt = 1'b0;
      end
    end
  end

  // occupied flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // entry value
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign occ     = occ_r;
  assign val     = val_r;
  assign tap_val = is_last ? val_r : '0;

endmodule

// ===== rtl/core/double_ended_queue_unit.sv =====
// double-ended queue top level: op decode, cell chain and result register
// the result strobe comes in the cycle after the word is accepted
// throughput: one operation per cycle once busy is low; the command goes to every cell of the chain in that cycle
// busy is high during reset and for the first cycle after it, low from then on
// reset empties the queue; stored values are not cleared
// results cannot be stalled and are shown for exactly one cycle
module double_ended_queue_unit #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::in_word_t  in_word,
  output logic               out_valid,
  output deq_pkg::out_word_t out_word
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                              busy_r;
  logic                              accept;
  logic [CNT_W-1:0]                  held_count_r;
  logic [CNT_W-1:0]                  held_count_nxt;
  logic                              out_valid_r;
  deq_pkg::out_word_t                out_word_r;
  deq_pkg::out_word_t                out_word_nxt;
  deq_pkg::cell_cmd_t                cmd;
  logic                              is_full;
  logic                              is_none;
  logic signed [deq_pkg::DATA_W-1:0] back_val;

  logic signed [deq_pkg::DATA_W-1:0] cell_val [DEPTH];
  logic                              cell_occ [DEPTH];
  logic signed [deq_pkg::DATA_W-1:0] cell_tap [DEPTH];

  assign accept  = start && !busy_r;
  assign is_full = (held_count_r == CNT_W'(DEPTH));
  assign is_none = (held_count_r == '0);

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [deq_pkg::DATA_W-1:0] lv;
    logic                              lo;
    logic signed [deq_pkg::DATA_W-1:0] rv;
    logic                              ro;
    if (i == 0) begin : g_head
      assign lv = in_word.data_value;
      assign lo = 1'b1;
    end else begin : g_mid_l
      assign lv = cell_val[i-1];
      assign lo = cell_occ[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_mid_r
      assign rv = cell_val[i+1];
      assign ro = cell_occ[i+1];
    end
    deq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .push_val  (in_word.data_value),
      .left_val  (lv),
      .left_occ  (lo),
      .right_val (rv),
      .right_occ (ro),
      .val       (cell_val[i]),
      .occ       (cell_occ[i]),
      .tap_val   (cell_tap[i])
    );
  end

  // back entry: only the last occupied cell drives its tap
  always_comb begin
    back_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_val = back_val | cell_tap[i];
    end
  end

  // operation decode
  always_comb begin
    cmd                       = '0;
    held_count_nxt            = held_count_r;
    out_word_nxt.popped_value = '0;
    out_word_nxt.status       = deq_pkg::ST_OK;
    unique case (in_word.operation)
      deq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          out_word_nxt.status = deq_pkg::ST_PUSH_FULL;
        end else begin
          cmd.push_front = accept;
          held_count_nxt = held_count_r + 1'b1;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          out_word_nxt.status = deq_pkg::ST_PUSH_FULL;
        end else begin
          cmd.push_back  = accept;
          held_count_nxt = held_count_r + 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (is_none) begin
          out_word_nxt.status = deq_pkg::ST_POP_EMPTY;
        end else begin
          cmd.pop_front             = accept;
          held_count_nxt            = held_count_r - 1'b1;
          out_word_nxt.popped_value = cell_val[0];
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (is_none) begin
          out_word_nxt.status = deq_pkg::ST_POP_EMPTY;
        end else begin
          cmd.pop_back              = accept;
          held_count_nxt            = held_count_r - 1'b1;
          out_word_nxt.popped_value = back_val;
        end
      end
      deq_pkg::OP_CLEAR: begin
        cmd.clear      = accept;
        held_count_nxt = '0;
      end
      default: begin
      end
    endcase
    out_word_nxt.entry_count = deq_pkg::COUNT_W'(held_count_nxt);
    out_word_nxt.is_empty    = (held_count_nxt == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      held_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      if (accept) begin
        held_count_r <= held_count_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/core/deq_checker.sv =====
// port-level checks for the double-ended queue and their bind to the top level
module deq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input deq_pkg::in_word_t  in_word,
  input logic               out_valid,
  input deq_pkg::out_word_t out_word
);

  // every accepted word gives a strobe in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted word gave no result");

  // no strobe without an accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without an accepted word");

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.is_empty) |-> (out_word.entry_count == '0))
    else $error("empty flag with non-zero count");

  // failed operations return no value; a full drop leaves entries held
  a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status == deq_pkg::ST_POP_EMPTY ||
                   out_word.status == deq_pkg::ST_PUSH_FULL))
    |-> (out_word.popped_value == '0 &&
         out_word.is_empty == (out_word.status == deq_pkg::ST_POP_EMPTY)))
    else $error("failed operation carries a value or wrong empty flag");

  // clear leaves the queue empty
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.operation == deq_pkg::OP_CLEAR)
    |=> (out_word.is_empty && out_word.status == deq_pkg::ST_OK))
    else $error("clear did not empty the queue");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);
